// File: rtl/cluster_charge_centroid_unit_macros.svh
// Assertion macros shared by the cluster centroid RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef CLUSTER_CHARGE_CENTROID_UNIT_MACROS_SVH
`define CLUSTER_CHARGE_CENTROID_UNIT_MACROS_SVH

// Condition and consequence in the same cycle.
`define CCCU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence in the cycle after the condition.
`define CCCU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ccc_pkg.sv
// Package for the cluster charge centroid unit: field widths, register indexes,
// reset values and the command/status structs between controller and datapath.
`default_nettype none

package ccc_pkg;

    localparam int CHANNEL_W    = 8;
    localparam int ADC_W        = 12;
    localparam int MEAN_W       = 16;
    localparam int WIDTH_W      = 12;
    localparam int FACTOR_W     = 8;
    localparam int CHARGE_W     = 20;
    localparam int TALLY_W      = 5;
    localparam int CENTROID_W   = 12;
    localparam int SECOND_OUT_W = 20;
    localparam int FIRST_SUM_W  = 28;
    localparam int SECOND_SUM_W = 36;
    localparam int AMP_W        = 16;
    localparam int THR_W        = FACTOR_W + WIDTH_W;
    localparam int AMP_CH_W     = AMP_W + CHANNEL_W;
    localparam int AMP_CH2_W    = AMP_CH_W + CHANNEL_W;
    localparam int FRAC_W       = 4;
    localparam int DIV_NUM_W    = SECOND_SUM_W + FRAC_W + 1;
    localparam int CFG_INDEX_W  = 4;
    localparam int CFG_DATA_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_SILICON_HIT  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_SILICON_SEED = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] REG_DIAMOND_HIT  = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_DIAMOND_SEED = CFG_INDEX_W'(3);

    localparam logic [FACTOR_W-1:0] HIT_FACTOR_RESET  = FACTOR_W'(48);
    localparam logic [FACTOR_W-1:0] SEED_FACTOR_RESET = FACTOR_W'(80);

    typedef enum logic {
        DIV_FIRST,
        DIV_SECOND
    } div_sel_t;

    typedef struct packed {
        logic     capture;
        logic     mult;
        logic     compare;
        logic     accum;
        logic     div_start;
        div_sel_t div_sel;
        logic     cent_load;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic charge_zero;
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/cluster_charge_centroid_unit.sv
// Top level of the cluster charge centroid unit: ports, controller and datapath.
// Depends on ccc_pkg, ccc_ctrl, ccc_datapath and the assertion macro header.
//
// Channel     Direction  Handshake           Carries
// s_          in         s_valid / s_ready   one strip channel of a cluster
// m_          out        m_valid / m_ready   one cluster result
// cfg_        in         cfg_valid/cfg_ready register index and factor value
//
// A channel that does not close its cluster passes through capture, multiply,
// compare and accumulate before the next channel can be accepted.
// A closing channel runs the shared one-bit-per-cycle divider twice over a
// 41-bit dividend; when the charge is zero both divisions are skipped.
// Reset (aresetn low, synchronous) restores the default factors and clears the
// accumulators; s_ready is registered and rises in the cycle after reset is released.
// A stalled result waits in the output register while further channels are
// taken; only the next closing channel waits for that result to leave.
`default_nettype none

`include "cluster_charge_centroid_unit_macros.svh"

module cluster_charge_centroid_unit #(
    parameter int MAX_CLUSTER_CHANNELS = 16,
    parameter int CHANNEL_COUNT        = 256
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // Configuration writes.
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [ccc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [ccc_pkg::CFG_DATA_W-1:0]        cfg_data,
    // Channel input.
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [ccc_pkg::CHANNEL_W-1:0]         s_channel_index,
    input  wire logic [ccc_pkg::ADC_W-1:0]             s_adc_value,
    input  wire logic [ccc_pkg::MEAN_W-1:0]            s_pedestal_mean,
    input  wire logic [ccc_pkg::WIDTH_W-1:0]           s_pedestal_width,
    input  wire logic                                  s_is_diamond,
    input  wire logic                                  s_last_in_cluster,
    // Cluster result.
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic      [ccc_pkg::CHARGE_W-1:0]          m_cluster_charge,
    output logic      [ccc_pkg::TALLY_W-1:0]           m_hit_count,
    output logic      [ccc_pkg::TALLY_W-1:0]           m_seed_count,
    output logic      [ccc_pkg::CENTROID_W-1:0]        m_centroid,
    output logic      [ccc_pkg::SECOND_OUT_W-1:0]      m_second_moment,
    output logic                                       m_no_charge
);

    ccc_pkg::dp_cmd_t    cmd;
    ccc_pkg::dp_status_t status;

    // Factor registers are plain flops and can take a write in any cycle.
    assign cfg_ready = 1'b1;

    // The controller owns both handshakes; the datapath only sees commands.
    ccc_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .status (status),
        .cmd    (cmd)
    );

    // The datapath holds the factors, the accumulators, the divider and the
    // result registers that drive the m_ payload.
    ccc_datapath #(
        .MAX_CLUSTER_CHANNELS(MAX_CLUSTER_CHANNELS),
        .CHANNEL_COUNT       (CHANNEL_COUNT)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_write        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_channel_index  (s_channel_index),
        .s_adc_value      (s_adc_value),
        .s_pedestal_mean  (s_pedestal_mean),
        .s_pedestal_width (s_pedestal_width),
        .s_is_diamond     (s_is_diamond),
        .s_last_in_cluster(s_last_in_cluster),
        .cmd              (cmd),
        .status           (status),
        .m_cluster_charge (m_cluster_charge),
        .m_hit_count      (m_hit_count),
        .m_seed_count     (m_seed_count),
        .m_centroid       (m_centroid),
        .m_second_moment  (m_second_moment),
        .m_no_charge      (m_no_charge)
    );

    // An empty cluster reports zero moments and zero charge.
    `CCCU_ASSERT_NOW(a_empty_cluster_zeroed, aclk, aresetn, m_valid && m_no_charge, m_centroid == '0 && m_second_moment == '0 && m_cluster_charge == '0, "empty cluster with nonzero fields")

    // Charge is only ever gathered by hit channels.
    `CCCU_ASSERT_NOW(a_charge_needs_hits, aclk, aresetn, m_valid && !m_no_charge, m_cluster_charge != '0 && m_hit_count != '0, "charge without hits")

    // One channel at a time: acceptance closes the input for the next cycle.
    `CCCU_ASSERT_NEXT(a_one_channel_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "input reopened while a channel is in work")

endmodule

`default_nettype wire

// File: rtl/ccc_divider.sv
// Restoring divider, one quotient bit per cycle, for the centroid unit.
// Stand-alone; no package dependency.
`default_nettype none

module ccc_divider #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 20
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] numerator,
    input  wire logic [DEN_W-1:0] denominator,
    output logic      [NUM_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_reg;
    logic [NUM_W-1:0] quo_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;
    logic             take;

    always_comb begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        take     = !diff[DEN_W+1];
        rem_next = take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], take};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= denominator;
            rem_reg <= '0;
            quo_reg <= numerator;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

// File: rtl/ccc_datapath.sv
// Datapath of the centroid unit: factor registers, per-channel threshold and
// moment arithmetic, saturating accumulators, shared divider and result registers.
// Depends on ccc_pkg and ccc_divider.
`default_nettype none

module ccc_datapath #(
    parameter int MAX_CLUSTER_CHANNELS = 16,
    parameter int CHANNEL_COUNT        = 256
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_write,
    input  wire logic [ccc_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  wire logic [ccc_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  wire logic [ccc_pkg::CHANNEL_W-1:0]         s_channel_index,
    input  wire logic [ccc_pkg::ADC_W-1:0]             s_adc_value,
    input  wire logic [ccc_pkg::MEAN_W-1:0]            s_pedestal_mean,
    input  wire logic [ccc_pkg::WIDTH_W-1:0]           s_pedestal_width,
    input  wire logic                                  s_is_diamond,
    input  wire logic                                  s_last_in_cluster,
    input  wire ccc_pkg::dp_cmd_t                      cmd,
    output ccc_pkg::dp_status_t                        status,
    output logic      [ccc_pkg::CHARGE_W-1:0]          m_cluster_charge,
    output logic      [ccc_pkg::TALLY_W-1:0]           m_hit_count,
    output logic      [ccc_pkg::TALLY_W-1:0]           m_seed_count,
    output logic      [ccc_pkg::CENTROID_W-1:0]        m_centroid,
    output logic      [ccc_pkg::SECOND_OUT_W-1:0]      m_second_moment,
    output logic                                       m_no_charge
);

    localparam int CH_TOP = (CHANNEL_COUNT - 1 > (1 << ccc_pkg::CHANNEL_W) - 1) ?
                            (1 << ccc_pkg::CHANNEL_W) - 1 : CHANNEL_COUNT - 1;
    localparam int SEEN_W = $clog2(MAX_CLUSTER_CHANNELS + 1);

    // Threshold factors.
    logic [ccc_pkg::FACTOR_W-1:0] si_hit_reg;
    logic [ccc_pkg::FACTOR_W-1:0] si_seed_reg;
    logic [ccc_pkg::FACTOR_W-1:0] di_hit_reg;
    logic [ccc_pkg::FACTOR_W-1:0] di_seed_reg;

    // Captured channel.
    logic [ccc_pkg::CHANNEL_W-1:0] ch_reg;
    logic [ccc_pkg::ADC_W-1:0]     adc_reg;
    logic [ccc_pkg::MEAN_W-1:0]    mean_reg;
    logic [ccc_pkg::WIDTH_W-1:0]   wid_reg;
    logic                          dia_reg;
    logic                          last_reg;
    logic [ccc_pkg::CHANNEL_W-1:0] ch_sat;

    // First stage: amplitude, thresholds and amplitude times channel.
    logic [ccc_pkg::MEAN_W-1:0]   scaled;
    logic                         pos_reg;
    logic [ccc_pkg::AMP_W-1:0]    amp_reg;
    logic [ccc_pkg::THR_W-1:0]    hthr_reg;
    logic [ccc_pkg::THR_W-1:0]    sthr_reg;
    logic [ccc_pkg::AMP_CH_W-1:0] amp_ch_reg;

    // Second stage: decisions and amplitude times channel squared.
    logic [ccc_pkg::THR_W-1:0]     amp8;
    logic                          hit_reg;
    logic                          seed_reg;
    logic [ccc_pkg::AMP_CH2_W-1:0] amp_ch2_reg;

    // Accumulators.
    logic [ccc_pkg::CHARGE_W-1:0]     charge_reg;
    logic [ccc_pkg::TALLY_W-1:0]      hit_tally_reg;
    logic [ccc_pkg::TALLY_W-1:0]      seed_tally_reg;
    logic [ccc_pkg::FIRST_SUM_W-1:0]  first_reg;
    logic [ccc_pkg::SECOND_SUM_W-1:0] second_reg;
    logic [SEEN_W-1:0]                seen_reg;
    logic                             active;
    logic [ccc_pkg::CHARGE_W:0]       charge_sum;
    logic [ccc_pkg::FIRST_SUM_W:0]    first_sum;
    logic [ccc_pkg::SECOND_SUM_W:0]   second_sum;

    // Division.
    logic [ccc_pkg::DIV_NUM_W-1:0]    half_charge;
    logic [ccc_pkg::DIV_NUM_W-1:0]    num_first;
    logic [ccc_pkg::DIV_NUM_W-1:0]    num_second;
    logic [ccc_pkg::DIV_NUM_W-1:0]    div_num;
    logic [ccc_pkg::DIV_NUM_W-1:0]    quotient;
    logic                             div_done;
    logic [ccc_pkg::CENTROID_W-1:0]   cent_sat;
    logic [ccc_pkg::SECOND_OUT_W-1:0] second_sat;
    logic [ccc_pkg::CENTROID_W-1:0]   cent_reg;

    // Results.
    logic [ccc_pkg::CHARGE_W-1:0]     out_charge_reg;
    logic [ccc_pkg::TALLY_W-1:0]      out_hit_reg;
    logic [ccc_pkg::TALLY_W-1:0]      out_seed_reg;
    logic [ccc_pkg::CENTROID_W-1:0]   out_cent_reg;
    logic [ccc_pkg::SECOND_OUT_W-1:0] out_second_reg;
    logic                             out_zero_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            si_hit_reg  <= ccc_pkg::HIT_FACTOR_RESET;
            si_seed_reg <= ccc_pkg::SEED_FACTOR_RESET;
            di_hit_reg  <= ccc_pkg::HIT_FACTOR_RESET;
            di_seed_reg <= ccc_pkg::SEED_FACTOR_RESET;
        end else if (cfg_write) begin
            case (cfg_index)
                ccc_pkg::REG_SILICON_HIT:  si_hit_reg  <= cfg_data;
                ccc_pkg::REG_SILICON_SEED: si_seed_reg <= cfg_data;
                ccc_pkg::REG_DIAMOND_HIT:  di_hit_reg  <= cfg_data;
                ccc_pkg::REG_DIAMOND_SEED: di_seed_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign ch_sat = (s_channel_index > ccc_pkg::CHANNEL_W'(CH_TOP)) ?
                    ccc_pkg::CHANNEL_W'(CH_TOP) : s_channel_index;

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            ch_reg   <= ch_sat;
            adc_reg  <= s_adc_value;
            mean_reg <= s_pedestal_mean;
            wid_reg  <= s_pedestal_width;
            dia_reg  <= s_is_diamond;
            last_reg <= s_last_in_cluster;
        end
    end

    assign scaled = {adc_reg, ccc_pkg::FRAC_W'(0)};

    always_ff @(posedge aclk) begin
        if (cmd.mult) begin
            pos_reg    <= scaled > mean_reg;
            amp_reg    <= scaled - mean_reg;
            hthr_reg   <= ccc_pkg::THR_W'(dia_reg ? di_hit_reg : si_hit_reg) *
                          ccc_pkg::THR_W'(wid_reg);
            sthr_reg   <= ccc_pkg::THR_W'(dia_reg ? di_seed_reg : si_seed_reg) *
                          ccc_pkg::THR_W'(wid_reg);
            amp_ch_reg <= ccc_pkg::AMP_CH_W'(scaled - mean_reg) *
                          ccc_pkg::AMP_CH_W'(ch_reg);
        end
    end

    assign amp8 = {amp_reg, ccc_pkg::FRAC_W'(0)};

    always_ff @(posedge aclk) begin
        if (cmd.compare) begin
            hit_reg     <= pos_reg && (amp8 > hthr_reg);
            seed_reg    <= pos_reg && (amp8 > sthr_reg);
            amp_ch2_reg <= ccc_pkg::AMP_CH2_W'(amp_ch_reg) * ccc_pkg::AMP_CH2_W'(ch_reg);
        end
    end

    always_comb begin
        active     = seen_reg < SEEN_W'(MAX_CLUSTER_CHANNELS);
        charge_sum = {1'b0, charge_reg} + (ccc_pkg::CHARGE_W + 1)'(amp_reg);
        first_sum  = {1'b0, first_reg} + (ccc_pkg::FIRST_SUM_W + 1)'(amp_ch_reg);
        second_sum = {1'b0, second_reg} + (ccc_pkg::SECOND_SUM_W + 1)'(amp_ch2_reg);
    end

    // Accumulators saturate at full width and clear on reset and when a result is loaded into the output registers.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.out_load) begin
            charge_reg     <= '0;
            hit_tally_reg  <= '0;
            seed_tally_reg <= '0;
            first_reg      <= '0;
            second_reg     <= '0;
            seen_reg       <= '0;
        end else if (cmd.accum && active) begin
            seen_reg <= seen_reg + SEEN_W'(1);
            if (hit_reg) begin
                charge_reg <= charge_sum[ccc_pkg::CHARGE_W] ? '1 :
                              charge_sum[ccc_pkg::CHARGE_W-1:0];
                first_reg  <= first_sum[ccc_pkg::FIRST_SUM_W] ? '1 :
                              first_sum[ccc_pkg::FIRST_SUM_W-1:0];
                second_reg <= second_sum[ccc_pkg::SECOND_SUM_W] ? '1 :
                              second_sum[ccc_pkg::SECOND_SUM_W-1:0];
                if (hit_tally_reg != '1) begin
                    hit_tally_reg <= hit_tally_reg + ccc_pkg::TALLY_W'(1);
                end
            end
            if (seed_reg && seed_tally_reg != '1) begin
                seed_tally_reg <= seed_tally_reg + ccc_pkg::TALLY_W'(1);
            end
        end
    end

    // Round to nearest by adding half the charge before dividing.
    always_comb begin
        half_charge = ccc_pkg::DIV_NUM_W'(charge_reg[ccc_pkg::CHARGE_W-1:1]);
        num_first   = ccc_pkg::DIV_NUM_W'({first_reg, ccc_pkg::FRAC_W'(0)}) + half_charge;
        num_second  = ccc_pkg::DIV_NUM_W'({second_reg, ccc_pkg::FRAC_W'(0)}) + half_charge;
        div_num     = (cmd.div_sel == ccc_pkg::DIV_SECOND) ? num_second : num_first;
        cent_sat    = (|quotient[ccc_pkg::DIV_NUM_W-1:ccc_pkg::CENTROID_W]) ? '1 :
                      quotient[ccc_pkg::CENTROID_W-1:0];
        second_sat  = (|quotient[ccc_pkg::DIV_NUM_W-1:ccc_pkg::SECOND_OUT_W]) ? '1 :
                      quotient[ccc_pkg::SECOND_OUT_W-1:0];
    end

    ccc_divider #(
        .NUM_W(ccc_pkg::DIV_NUM_W),
        .DEN_W(ccc_pkg::CHARGE_W)
    ) u_divider (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cmd.div_start),
        .numerator  (div_num),
        .denominator(charge_reg),
        .quotient   (quotient),
        .done       (div_done)
    );

    always_ff @(posedge aclk) begin
        if (cmd.cent_load) begin
            cent_reg <= cent_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_charge_reg <= charge_reg;
            out_hit_reg    <= hit_tally_reg;
            out_seed_reg   <= seed_tally_reg;
            if (charge_reg == '0) begin
                out_cent_reg   <= '0;
                out_second_reg <= '0;
                out_zero_reg   <= 1'b1;
            end else begin
                out_cent_reg   <= cent_reg;
                out_second_reg <= second_sat;
                out_zero_reg   <= 1'b0;
            end
        end
    end

    always_comb begin
        status.last        = last_reg;
        status.charge_zero = charge_reg == '0;
        status.div_done    = div_done;
    end

    assign m_cluster_charge = out_charge_reg;
    assign m_hit_count      = out_hit_reg;
    assign m_seed_count     = out_seed_reg;
    assign m_centroid       = out_cent_reg;
    assign m_second_moment  = out_second_reg;
    assign m_no_charge      = out_zero_reg;

endmodule

`default_nettype wire

// File: rtl/ccc_ctrl.sv
// Controller of the centroid unit: sequences one channel through the datapath
// and runs the two divisions that close a cluster. Depends on ccc_pkg.
`default_nettype none

module ccc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire ccc_pkg::dp_status_t status,
    output ccc_pkg::dp_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_CMP,
        ST_ACCUM,
        ST_LAUNCH,
        ST_WAIT_CENT,
        ST_WAIT_SEC,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   s_ready_reg;
    logic   m_valid_reg;
    logic   out_free;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        out_free   = !m_valid_reg || m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mult   = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP: begin
                cmd.compare = 1'b1;
                state_next  = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = status.last ? ST_LAUNCH : ST_IDLE;
            end
            ST_LAUNCH: begin
                if (status.charge_zero) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ccc_pkg::DIV_FIRST;
                    state_next    = ST_WAIT_CENT;
                end
            end
            ST_WAIT_CENT: begin
                if (status.div_done) begin
                    cmd.cent_load = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = ccc_pkg::DIV_SECOND;
                    state_next    = ST_WAIT_SEC;
                end
            end
            ST_WAIT_SEC: begin
                cmd.div_sel = ccc_pkg::DIV_SECOND;
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                cmd.div_sel = ccc_pkg::DIV_SECOND;
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= state_next == ST_IDLE;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for cluster_charge_centroid_unit: directed and random strip channels,
// a cycle-free predictor of the cluster sums and quotients, and an in-order result scoreboard.
// Depends on ccc_pkg and the cluster_charge_centroid_unit RTL.

module testbench;

    localparam int MAX_CLUSTER_CHANNELS = 16;
    localparam int CHANNEL_COUNT        = 256;
    localparam int HALF_PERIOD          = 10;
    localparam int RESET_CYCLES         = 9;
    // Long enough for a closing channel still in work to finish its divisions.
    localparam int SETTLE_CYCLES        = 120;
    // The slowest correct run closes a cluster on every channel, with stalls and gaps, for
    // roughly 1150 channels; the limit leaves a wide margin over such a run.
    localparam int CYCLE_LIMIT          = 600000;
    localparam int GAP_PERCENT          = 6;
    localparam int RANDOM_PHASES        = 7;
    localparam int STEADY_PHASE         = 3;
    localparam int HALF_PHASE_ITEMS     = 66;

    localparam logic [ccc_pkg::CFG_INDEX_W-1:0] REG_FIRST_UNUSED =
        ccc_pkg::REG_DIAMOND_SEED + 1'b1;
    localparam logic [ccc_pkg::CFG_INDEX_W-1:0] REG_LAST_UNUSED  = '1;

    localparam longint unsigned CHARGE_TOP     = (64'd1 << ccc_pkg::CHARGE_W) - 1;
    localparam longint unsigned FIRST_TOP      = (64'd1 << ccc_pkg::FIRST_SUM_W) - 1;
    localparam longint unsigned SECOND_TOP     = (64'd1 << ccc_pkg::SECOND_SUM_W) - 1;
    localparam longint unsigned CENTROID_TOP   = (64'd1 << ccc_pkg::CENTROID_W) - 1;
    localparam longint unsigned SECOND_OUT_TOP = (64'd1 << ccc_pkg::SECOND_OUT_W) - 1;

    // One strip channel as it travels on the input channel.
    typedef struct packed {
        logic [ccc_pkg::CHANNEL_W-1:0] channel_index;
        logic [ccc_pkg::ADC_W-1:0]     adc_value;
        logic [ccc_pkg::MEAN_W-1:0]    pedestal_mean;
        logic [ccc_pkg::WIDTH_W-1:0]   pedestal_width;
        logic                          is_diamond;
        logic                          last_in_cluster;
    } strip_chan_t;

    // One cluster summary as it leaves on the result channel.
    typedef struct packed {
        logic [ccc_pkg::CHARGE_W-1:0]     cluster_charge;
        logic [ccc_pkg::TALLY_W-1:0]      hit_count;
        logic [ccc_pkg::TALLY_W-1:0]      seed_count;
        logic [ccc_pkg::CENTROID_W-1:0]   centroid;
        logic [ccc_pkg::SECOND_OUT_W-1:0] second_moment;
        logic                             no_charge;
    } cluster_result_t;

    // Every block input starts from a known value.
    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [ccc_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [ccc_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    strip_chan_t                      s_chan    = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    logic [ccc_pkg::CHARGE_W-1:0]     m_cluster_charge;
    logic [ccc_pkg::TALLY_W-1:0]      m_hit_count;
    logic [ccc_pkg::TALLY_W-1:0]      m_seed_count;
    logic [ccc_pkg::CENTROID_W-1:0]   m_centroid;
    logic [ccc_pkg::SECOND_OUT_W-1:0] m_second_moment;
    logic                             m_no_charge;

    // Channels waiting for the driver; the front one is on the bus while s_valid is high.
    strip_chan_t     pending_chans[$];
    // Cluster summaries predicted at channel acceptance, oldest first.
    cluster_result_t expected_clusters[$];
    int unsigned     mismatch_count = 0;
    int unsigned     cycle_count    = 0;
    // While set, neither side inserts random gaps.
    bit              steady         = 1'b0;

    // Predictor copy of the factor registers and of the cluster accumulators.
    logic [ccc_pkg::FACTOR_W-1:0]     silicon_hit_f  = ccc_pkg::HIT_FACTOR_RESET;
    logic [ccc_pkg::FACTOR_W-1:0]     silicon_seed_f = ccc_pkg::SEED_FACTOR_RESET;
    logic [ccc_pkg::FACTOR_W-1:0]     diamond_hit_f  = ccc_pkg::HIT_FACTOR_RESET;
    logic [ccc_pkg::FACTOR_W-1:0]     diamond_seed_f = ccc_pkg::SEED_FACTOR_RESET;
    logic [ccc_pkg::CHARGE_W-1:0]     charge_acc     = '0;
    logic [ccc_pkg::TALLY_W-1:0]      hit_acc        = '0;
    logic [ccc_pkg::TALLY_W-1:0]      seed_acc       = '0;
    logic [ccc_pkg::FIRST_SUM_W-1:0]  first_acc      = '0;
    logic [ccc_pkg::SECOND_SUM_W-1:0] second_acc     = '0;
    int unsigned                      chans_in_cluster = 0;

    cluster_charge_centroid_unit #(
        .MAX_CLUSTER_CHANNELS(MAX_CLUSTER_CHANNELS),
        .CHANNEL_COUNT       (CHANNEL_COUNT)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_channel_index  (s_chan.channel_index),
        .s_adc_value      (s_chan.adc_value),
        .s_pedestal_mean  (s_chan.pedestal_mean),
        .s_pedestal_width (s_chan.pedestal_width),
        .s_is_diamond     (s_chan.is_diamond),
        .s_last_in_cluster(s_chan.last_in_cluster),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cluster_charge (m_cluster_charge),
        .m_hit_count      (m_hit_count),
        .m_seed_count     (m_seed_count),
        .m_centroid       (m_centroid),
        .m_second_moment  (m_second_moment),
        .m_no_charge      (m_no_charge)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Saturating accumulation: once the top is reached the sum stays there.
    function automatic longint unsigned sat_add(longint unsigned acc, longint unsigned inc,
                                                longint unsigned top);
        if (acc >= top || inc > top - acc) return top;
        return acc + inc;
    endfunction

    // Quotient rounded to nearest with halves going up, clipped to the output range.
    function automatic longint unsigned round_quotient(longint unsigned num,
                                                       longint unsigned den,
                                                       longint unsigned top);
        longint unsigned q;
        q = (num + (den >> 1)) / den;
        return (q > top) ? top : q;
    endfunction

    // Folds one accepted channel into the running cluster and, on the closing channel,
    // queues the cluster summary the block has to produce.
    function automatic void absorb_channel(strip_chan_t c);
        logic [ccc_pkg::CHANNEL_W-1:0] pos;
        logic [ccc_pkg::AMP_W-1:0]     scaled;
        logic [ccc_pkg::AMP_W-1:0]     amp;
        logic [ccc_pkg::THR_W-1:0]     amp_q8;
        logic [ccc_pkg::THR_W-1:0]     hit_thr;
        logic [ccc_pkg::THR_W-1:0]     seed_thr;
        logic [ccc_pkg::FACTOR_W-1:0]  hit_f;
        logic [ccc_pkg::FACTOR_W-1:0]  seed_f;
        cluster_result_t               r;
        pos = (c.channel_index > CHANNEL_COUNT - 1) ?
              ccc_pkg::CHANNEL_W'(CHANNEL_COUNT - 1) : c.channel_index;
        // Channels past the cluster length limit are dropped, but a closing mark still counts.
        if (chans_in_cluster < MAX_CLUSTER_CHANNELS) begin
            chans_in_cluster++;
            scaled = {c.adc_value, {ccc_pkg::FRAC_W{1'b0}}};
            // Only a strictly positive amplitude can make a hit or a seed.
            if (scaled > c.pedestal_mean) begin
                amp      = scaled - c.pedestal_mean;
                amp_q8   = {amp, {ccc_pkg::FRAC_W{1'b0}}};
                hit_f    = c.is_diamond ? diamond_hit_f : silicon_hit_f;
                seed_f   = c.is_diamond ? diamond_seed_f : silicon_seed_f;
                hit_thr  = ccc_pkg::THR_W'(hit_f) * ccc_pkg::THR_W'(c.pedestal_width);
                seed_thr = ccc_pkg::THR_W'(seed_f) * ccc_pkg::THR_W'(c.pedestal_width);
                if (amp_q8 > hit_thr) begin
                    charge_acc = ccc_pkg::CHARGE_W'(sat_add(charge_acc, amp, CHARGE_TOP));
                    if (hit_acc != '1) hit_acc++;
                    first_acc  = ccc_pkg::FIRST_SUM_W'(sat_add(first_acc,
                                                               64'(amp) * 64'(pos),
                                                               FIRST_TOP));
                    second_acc = ccc_pkg::SECOND_SUM_W'(sat_add(second_acc,
                                                        64'(amp) * 64'(pos) * 64'(pos),
                                                        SECOND_TOP));
                end
                // The seed test stands apart from the hit test.
                if (amp_q8 > seed_thr) begin
                    if (seed_acc != '1) seed_acc++;
                end
            end
        end
        if (c.last_in_cluster) begin
            r.cluster_charge = charge_acc;
            r.hit_count      = hit_acc;
            r.seed_count     = seed_acc;
            r.no_charge      = (charge_acc == '0);
            if (r.no_charge) begin
                r.centroid      = '0;
                r.second_moment = '0;
            end else begin
                r.centroid      = ccc_pkg::CENTROID_W'(
                    round_quotient(64'(first_acc) << ccc_pkg::FRAC_W, charge_acc,
                                   CENTROID_TOP));
                r.second_moment = ccc_pkg::SECOND_OUT_W'(
                    round_quotient(64'(second_acc) << ccc_pkg::FRAC_W, charge_acc,
                                   SECOND_OUT_TOP));
            end
            expected_clusters = {expected_clusters, r};
            charge_acc       = '0;
            hit_acc          = '0;
            seed_acc         = '0;
            first_acc        = '0;
            second_acc       = '0;
            chans_in_cluster = 0;
        end
    endfunction

    function automatic strip_chan_t make_chan(int ch, int adc, int mean, int wid,
                                              bit dia, bit last);
        strip_chan_t c;
        c.channel_index   = ccc_pkg::CHANNEL_W'(ch);
        c.adc_value       = ccc_pkg::ADC_W'(adc);
        c.pedestal_mean   = ccc_pkg::MEAN_W'(mean);
        c.pedestal_width  = ccc_pkg::WIDTH_W'(wid);
        c.is_diamond      = dia;
        c.last_in_cluster = last;
        return c;
    endfunction

    // Appends one channel to the driver's queue.
    function automatic void enqueue_chan(strip_chan_t c);
        pending_chans = {pending_chans, c};
    endfunction

    // Queues one well-formed cluster with random content and returns its length. Most
    // channels sit above their pedestal so that hits and seeds are common; a few clusters
    // run past the length limit.
    function automatic int queue_cluster();
        int len;
        int start;
        int ch;
        int mean;
        int base;
        int adc;
        int wid;
        int pick;
        bit dia;
        pick  = $urandom_range(99);
        if (pick < 6) len = $urandom_range(MAX_CLUSTER_CHANNELS + 1, MAX_CLUSTER_CHANNELS + 4);
        else if (pick < 20) len = 1;
        else len = $urandom_range(2, MAX_CLUSTER_CHANNELS);
        start = $urandom_range(CHANNEL_COUNT - 1);
        dia   = 1'($urandom_range(1));
        for (int k = 0; k < len; k++) begin
            ch   = ($urandom_range(99) < 5) ? $urandom_range(CHANNEL_COUNT - 1) : start + k;
            if (ch > CHANNEL_COUNT - 1) ch = CHANNEL_COUNT - 1;
            mean = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(24000);
            wid  = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(160);
            base = mean >> ccc_pkg::FRAC_W;
            if ($urandom_range(99) < 15) begin
                adc = base - $urandom_range(base < 50 ? base : 50);
            end else if ($urandom_range(99) < 10) begin
                adc = base + $urandom_range(4095);
            end else begin
                adc = base + $urandom_range(1200);
            end
            if (adc > 4095) adc = 4095;
            enqueue_chan(make_chan(ch, adc, mean, wid,
                                   ($urandom_range(9) == 0) ? !dia : dia,
                                   k == len - 1));
        end
        return len;
    endfunction

    // Mostly well-formed clusters, the rest fully random channels that may or may not
    // close a cluster. A final cluster always leaves the block between clusters.
    function automatic void queue_random_items(int count);
        int added;
        added = 0;
        while (added < count) begin
            if ($urandom_range(99) < 85) begin
                added += queue_cluster();
            end else begin
                enqueue_chan(make_chan($urandom_range(CHANNEL_COUNT - 1),
                                       $urandom_range(4095), $urandom_range(65535),
                                       $urandom_range(4095), 1'($urandom_range(1)),
                                       $urandom_range(3) == 0));
                added++;
            end
        end
        void'(queue_cluster());
    endfunction

    // One register write transaction; the predictor takes the value once it is accepted.
    task automatic write_register(logic [ccc_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [ccc_pkg::CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            ccc_pkg::REG_SILICON_HIT:  silicon_hit_f  = val;
            ccc_pkg::REG_SILICON_SEED: silicon_seed_f = val;
            ccc_pkg::REG_DIAMOND_HIT:  diamond_hit_f  = val;
            ccc_pkg::REG_DIAMOND_SEED: diamond_seed_f = val;
            default: ;  // indexes past the last register are dropped by the block
        endcase
    endtask

    // Writes all four factors, preceded by a write to an unused index that must change nothing.
    task automatic apply_factors(logic [ccc_pkg::FACTOR_W-1:0] si_hit,
                                 logic [ccc_pkg::FACTOR_W-1:0] si_seed,
                                 logic [ccc_pkg::FACTOR_W-1:0] di_hit,
                                 logic [ccc_pkg::FACTOR_W-1:0] di_seed);
        write_register(ccc_pkg::CFG_INDEX_W'($urandom_range(REG_LAST_UNUSED, REG_FIRST_UNUSED)),
                       ccc_pkg::CFG_DATA_W'($urandom_range(255)));
        write_register(ccc_pkg::REG_SILICON_HIT, si_hit);
        write_register(ccc_pkg::REG_SILICON_SEED, si_seed);
        write_register(ccc_pkg::REG_DIAMOND_HIT, di_hit);
        write_register(ccc_pkg::REG_DIAMOND_SEED, di_seed);
    endtask

    // Holds the sender back until every queued channel is taken and every summary is out.
    task automatic wait_for_results();
        @(posedge aclk);
        while (pending_chans.size() != 0 || expected_clusters.size() != 0) @(posedge aclk);
    endtask

    // Driver: presents the front pending channel and keeps it steady until the transaction
    // completes. Prediction runs on the channel as it is accepted, so the factor copy in
    // use is always the one the block holds at that moment.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_channel(s_chan);
                void'(pending_chans.pop_front());
            end
            if (!s_valid || s_ready) begin
                if (pending_chans.size() != 0 &&
                    (steady || $urandom_range(99) >= GAP_PERCENT)) begin
                    s_valid <= 1'b1;
                    s_chan  <= pending_chans[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Monitor: compares every accepted summary, field by field, with the oldest prediction,
    // and stalls the result channel now and then.
    always @(posedge aclk) begin : result_monitor
        cluster_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_clusters.size() == 0) begin
                    $error("cluster summary with no cluster closed: charge %0d",
                           m_cluster_charge);
                    mismatch_count++;
                end else begin
                    want = expected_clusters.pop_front();
                    check_field("cluster_charge", want.cluster_charge, m_cluster_charge);
                    check_field("hit_count", want.hit_count, m_hit_count);
                    check_field("seed_count", want.seed_count, m_seed_count);
                    check_field("centroid", want.centroid, m_centroid);
                    check_field("second_moment", want.second_moment, m_second_moment);
                    check_field("no_charge", want.no_charge, m_no_charge);
                end
            end
            m_ready <= steady || ($urandom_range(99) >= GAP_PERCENT);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[cluster_charge_centroid_unit] ERROR");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset factors (3.0 for hits, 5.0 for seeds). The write to an
        // unused register index must leave them as they are.
        write_register(REG_FIRST_UNUSED, ccc_pkg::CFG_DATA_W'($urandom_range(255)));
        @(negedge aclk);
        // A cluster with zero charge.
        enqueue_chan(make_chan(0, 0, 0, 0, 1'b0, 1'b1));
        // An amplitude of exactly zero is neither hit nor seed.
        enqueue_chan(make_chan(17, 100, 1600, 0, 1'b1, 1'b1));
        // Field extremes: full-scale hit at the top channel, then a negative amplitude.
        enqueue_chan(make_chan(CHANNEL_COUNT - 1, 4095, 0, 0, 1'b1, 1'b0));
        enqueue_chan(make_chan(0, 4095, 65535, 4095, 1'b0, 1'b1));
        // Threshold edges with a width of 1.0: amplitude equal to the hit threshold, just
        // above it, equal to the seed threshold, and just above that.
        enqueue_chan(make_chan(40, 10, 112, 16, 1'b0, 1'b0));
        enqueue_chan(make_chan(41, 10, 111, 16, 1'b0, 1'b0));
        enqueue_chan(make_chan(42, 10, 80, 16, 1'b1, 1'b0));
        enqueue_chan(make_chan(43, 10, 79, 16, 1'b1, 1'b1));
        // An overlong cluster: the closing channel lies past the limit and only closes it.
        for (int k = 0; k <= MAX_CLUSTER_CHANNELS; k++) begin
            enqueue_chan(make_chan((k == MAX_CLUSTER_CHANNELS) ? CHANNEL_COUNT - 1 : 100 + k,
                                   2000, 16000, 4095, 1'(k % 2),
                                   k == MAX_CLUSTER_CHANNELS));
        end
        wait_for_results();

        // Random phases, each under its own factor setting. The factors only change once
        // the block has gone quiet after the last summary.
        for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
            repeat (SETTLE_CYCLES) @(posedge aclk);
            case (phase)
                1:       apply_factors('0, '0, '0, '0);
                2:       apply_factors('1, '1, '1, '1);
                3:       apply_factors(8'd16, 8'd32, 8'd200, 8'd255);
                default: apply_factors(ccc_pkg::FACTOR_W'($urandom_range(255)),
                                       ccc_pkg::FACTOR_W'($urandom_range(255)),
                                       ccc_pkg::FACTOR_W'($urandom_range(255)),
                                       ccc_pkg::FACTOR_W'($urandom_range(255)));
            endcase
            @(negedge aclk);
            steady = (phase == STEADY_PHASE);
            queue_random_items(HALF_PHASE_ITEMS);
            // The sender stops here until every summary so far has come back.
            wait_for_results();
            @(negedge aclk);
            queue_random_items(HALF_PHASE_ITEMS);
            wait_for_results();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[cluster_charge_centroid_unit] OK");
        end else begin
            $display("[cluster_charge_centroid_unit] ERROR");
        end
        $finish;
    end

endmodule
